// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is high
`define TODC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define TODC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/todc_pkg.sv =====
// ----------------------------------------------------------------------------
// todc_pkg
// types and constants of the time-of-day clock with session timeout
// ----------------------------------------------------------------------------
package todc_pkg;

   // command codes of the mode field
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;
   localparam logic [1:0] MODE_STOP  = 2'd3;

   // register indexes of the csr port
   localparam logic [1:0] CSR_DISPLAY_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SESSION_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_BLINK_START    = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   // register reset values
   localparam logic [6:0] SESSION_LIMIT_RESET = 7'd120;
   localparam logic [6:0] BLINK_START_RESET   = 7'd100;

   // time limits
   localparam logic [5:0] SECOND_MAX       = 6'd59;
   localparam logic [5:0] MINUTE_MAX       = 6'd59;
   localparam logic [4:0] HOUR_MAX         = 5'd23;
   localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

   localparam int TICKS_PER_SECOND_DEFAULT = 4;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] set_hours;
      logic [5:0] set_minutes;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       second_done;
      logic       refresh_display;
      logic       session_active;
      logic       session_overtime;
      logic [6:0] session_seconds;
      logic       led_on;
      logic       set_rejected;
   } rsp_payload_type;

endpackage

// ===== rtl/time_of_day_clock_with_session_timeout_core.sv =====
// ----------------------------------------------------------------------------
// time_of_day_clock_with_session_timeout_core
// hh:mm:ss clock driven by sub-second ticks, with a timed session and led
// ----------------------------------------------------------------------------
// path: a transferred request passes the input register, then the result register, to the response
// throughput: one item per cycle; the only limit is the response side stalling
// each item's state update is a single pass between the input and result registers
// reset (synchronous, active high): time, tick phase, session and led clear,
// session_limit returns to 120, blink_start to 100, display_enable to 0
module time_of_day_clock_with_session_timeout_core #(
   parameter int TICKS_PER_SECOND = todc_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  todc_pkg::req_payload_type        req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output todc_pkg::rsp_payload_type        rsp_data,
   // register write port
   input  logic                             csr_we,
   input  logic [todc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [todc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // tick phase counter width, at least one bit
   localparam int PhaseW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(TICKS_PER_SECOND - 1);

   // configuration registers
   logic       display_enable_ff;
   logic [6:0] session_limit_ff;
   logic [6:0] blink_start_ff;

   // input stage
   logic                      in_valid_ff;
   todc_pkg::req_payload_type in_data_ff;

   // clock and session state
   logic [PhaseW-1:0] tick_phase_ff,      tick_phase_in;
   logic [4:0]        clock_hours_ff,     clock_hours_in;
   logic [5:0]        clock_minutes_ff,   clock_minutes_in;
   logic [5:0]        clock_seconds_ff,   clock_seconds_in;
   logic              session_running_ff, session_running_in;
   logic [6:0]        session_count_ff,   session_count_in;
   logic              overtime_flag_ff,   overtime_flag_in;
   logic              led_level_ff,       led_level_in;

   // result stage
   logic                      out_valid_ff;
   todc_pkg::rsp_payload_type out_data_ff, out_data_in;

   logic       advance;
   logic       req_xfer;
   logic [7:0] session_inc;
   logic       second_done;
   logic       set_bad;

   // the input stage moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         display_enable_ff <= 1'b0;
         session_limit_ff  <= todc_pkg::SESSION_LIMIT_RESET;
         blink_start_ff    <= todc_pkg::BLINK_START_RESET;
      end else if (csr_we) begin
         case (csr_index)
            todc_pkg::CSR_DISPLAY_ENABLE: display_enable_ff <= csr_wdata[0];
            todc_pkg::CSR_SESSION_LIMIT:  session_limit_ff  <= csr_wdata;
            todc_pkg::CSR_BLINK_START:    blink_start_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // next state for the item in the input stage
   always_comb begin
      tick_phase_in      = tick_phase_ff;
      clock_hours_in     = clock_hours_ff;
      clock_minutes_in   = clock_minutes_ff;
      clock_seconds_in   = clock_seconds_ff;
      session_running_in = session_running_ff;
      session_count_in   = session_count_ff;
      overtime_flag_in   = overtime_flag_ff;
      led_level_in       = led_level_ff;
      second_done        = 1'b0;
      set_bad            = 1'b0;
      session_inc        = {1'b0, session_count_ff} + 8'd1;

      case (in_data_ff.mode)
         todc_pkg::MODE_TICK: begin
            if (tick_phase_ff != PhaseLast) begin
               tick_phase_in = tick_phase_ff + PhaseW'(1);
            end else begin
               tick_phase_in = '0;
               second_done   = 1'b1;
               // session step, timeout once the incremented count reaches the limit
               if (session_running_ff) begin
                  if (session_inc >= {1'b0, session_limit_ff}) begin
                     session_count_in   = '0;
                     led_level_in       = 1'b0;
                     session_running_in = 1'b0;
                     overtime_flag_in   = 1'b1;
                  end else begin
                     session_count_in = session_inc[6:0];
                  end
               end
               // seconds, minutes, hours with 24-hour wrap
               if (clock_seconds_ff < todc_pkg::SECOND_MAX) begin
                  clock_seconds_in = clock_seconds_ff + 6'd1;
               end else begin
                  clock_seconds_in = '0;
                  if (clock_minutes_ff < todc_pkg::MINUTE_MAX) begin
                     clock_minutes_in = clock_minutes_ff + 6'd1;
                  end else begin
                     clock_minutes_in = '0;
                     if (clock_hours_ff < todc_pkg::HOUR_MAX) begin
                        clock_hours_in = clock_hours_ff + 5'd1;
                     end else begin
                        clock_hours_in = '0;
                     end
                  end
               end
            end
            // blink on every tick at or past the threshold, after any timeout
            if (session_count_in >= blink_start_ff) begin
               led_level_in = !led_level_in;
            end
         end
         todc_pkg::MODE_SET: begin
            if (in_data_ff.set_hours < todc_pkg::HOURS_PER_DAY &&
                in_data_ff.set_minutes < todc_pkg::MINUTES_PER_HOUR) begin
               clock_hours_in   = in_data_ff.set_hours;
               clock_minutes_in = in_data_ff.set_minutes;
            end else begin
               set_bad = 1'b1;
            end
         end
         todc_pkg::MODE_START: begin
            session_running_in = 1'b1;
            session_count_in   = '0;
            overtime_flag_in   = 1'b0;
            led_level_in       = 1'b0;
         end
         todc_pkg::MODE_STOP: begin
            // overtime stays visible after a stop
            session_running_in = 1'b0;
            session_count_in   = '0;
            led_level_in       = 1'b0;
         end
         default: begin
         end
      endcase

      out_data_in.hours            = clock_hours_in;
      out_data_in.minutes          = clock_minutes_in;
      out_data_in.seconds          = clock_seconds_in;
      out_data_in.second_done      = second_done;
      out_data_in.refresh_display  = second_done && display_enable_ff;
      out_data_in.session_active   = session_running_in;
      out_data_in.session_overtime = overtime_flag_in;
      out_data_in.session_seconds  = session_count_in;
      out_data_in.led_on           = led_level_in;
      out_data_in.set_rejected     = set_bad;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         tick_phase_ff      <= '0;
         clock_hours_ff     <= '0;
         clock_minutes_ff   <= '0;
         clock_seconds_ff   <= '0;
         session_running_ff <= 1'b0;
         session_count_ff   <= '0;
         overtime_flag_ff   <= 1'b0;
         led_level_ff       <= 1'b0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         // state commits only when the item moves into the result register
         if (advance) begin
            tick_phase_ff      <= tick_phase_in;
            clock_hours_ff     <= clock_hours_in;
            clock_minutes_ff   <= clock_minutes_in;
            clock_seconds_ff   <= clock_seconds_in;
            session_running_ff <= session_running_in;
            session_count_ff   <= session_count_in;
            overtime_flag_ff   <= overtime_flag_in;
            led_level_ff       <= led_level_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== rtl/todc_checker.sv =====
// ----------------------------------------------------------------------------
// todc_checker
// port-level checks of the time-of-day clock core, bound to the core module
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module todc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input todc_pkg::rsp_payload_type rsp_data
);

   `TODC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

   `TODC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   `TODC_ASSERT(a_refresh_on_second, clock, reset, rsp_valid && rsp_data.refresh_display |-> rsp_data.second_done, "refresh without a completed second")

   `TODC_ASSERT(a_idle_count_zero, clock, reset, rsp_valid && !rsp_data.session_active |-> rsp_data.session_seconds == 7'd0, "session count nonzero while no session runs")

   `TODC_ASSERT(a_overtime_ends_session, clock, reset, rsp_valid |-> !(rsp_data.session_active && rsp_data.session_overtime), "overtime while session active")

endmodule

bind time_of_day_clock_with_session_timeout_core todc_checker u_todc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
